// ===== design/tqsd_pkg.sv =====
`timescale 1ns / 1ps

package tqsd_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int INDEX_BITS  = 16;
    localparam int TIME_BITS   = 32;
    localparam int HEAD_BITS   = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] USE_IDLE  = 2'd0;
    localparam logic [1:0] USE_ENTER = 2'd1;
    localparam logic [1:0] USE_EXIT  = 2'd2;

    localparam logic ACT_ARRIVE = 1'b0;
    localparam logic ACT_FLUSH  = 1'b1;

    localparam logic DIR_ENTER = 1'b0;
    localparam logic DIR_EXIT  = 1'b1;

    typedef struct packed {
        logic                  action;
        logic [TIME_BITS-1:0]  arrival_time;
        logic                  direction;
        logic [INDEX_BITS-1:0] person_index;
    } t_cmd;

    typedef struct packed {
        logic [INDEX_BITS-1:0] granted_index;
        logic [TIME_BITS-1:0]  cross_time;
        logic                  granted_direction;
        logic                  overflow;
        logic                  last;
    } t_res;

endpackage

// ===== design/tqsd_cmd_fifo.sv =====
`timescale 1ns / 1ps

module tqsd_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  tqsd_pkg::t_cmd i_wdata,
    output logic          o_full,
    input  logic          i_rd,
    output tqsd_pkg::t_cmd o_rdata,
    output logic          o_empty
);

    tqsd_pkg::t_cmd r_mem [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_cnt;
    logic           wr_en;
    logic           rd_en;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wptr <= !r_wptr;
            end
            if (rd_en) begin
                r_rptr <= !r_rptr;
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== design/tqsd_res_fifo.sv =====
`timescale 1ns / 1ps

module tqsd_res_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  tqsd_pkg::t_res i_wdata,
    output logic          o_full,
    input  logic          i_rd,
    output tqsd_pkg::t_res o_rdata,
    output logic          o_empty
);

    tqsd_pkg::t_res r_mem [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_cnt;
    logic           wr_en;
    logic           rd_en;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wptr <= !r_wptr;
            end
            if (rd_en) begin
                r_rptr <= !r_rptr;
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== design/tqsd_engine.sv =====
`timescale 1ns / 1ps

module tqsd_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  tqsd_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    input  logic           i_res_full,
    output logic           o_res_wr,
    output tqsd_pkg::t_res o_res
);

    logic [tqsd_pkg::INDEX_BITS-1:0] r_enter_q [tqsd_pkg::QUEUE_DEPTH];
    logic [tqsd_pkg::INDEX_BITS-1:0] r_exit_q  [tqsd_pkg::QUEUE_DEPTH];
    logic [tqsd_pkg::HEAD_BITS-1:0]  r_ehead;
    logic [tqsd_pkg::HEAD_BITS-1:0]  r_xhead;
    logic [tqsd_pkg::CNT_BITS-1:0]   r_ecnt;
    logic [tqsd_pkg::CNT_BITS-1:0]   r_xcnt;
    logic [tqsd_pkg::TIME_BITS-1:0]  r_cur;
    logic [1:0]                      r_last_use;

    logic                            any_wait;
    logic                            is_early;
    logic                            take_exit;
    logic [tqsd_pkg::INDEX_BITS-1:0] head_data;
    logic [tqsd_pkg::CNT_BITS-1:0]   ecnt_after;
    logic [tqsd_pkg::CNT_BITS-1:0]   xcnt_after;
    logic                            after_wait;
    logic                            ovf_after;
    logic                            ovf_now;
    logic [tqsd_pkg::TIME_BITS-1:0]  cur_inc;
    logic                            go;
    logic                            do_grant;
    logic                            do_finish;
    logic                            do_drop;
    logic                            grant_last;
    logic [tqsd_pkg::CNT_BITS:0]     ecnt_sum;
    logic [tqsd_pkg::CNT_BITS:0]     xcnt_sum;
    logic [tqsd_pkg::HEAD_BITS-1:0]  etail;
    logic [tqsd_pkg::HEAD_BITS-1:0]  xtail;
    logic [tqsd_pkg::HEAD_BITS-1:0]  ehead_inc;
    logic [tqsd_pkg::HEAD_BITS-1:0]  xhead_inc;

    localparam logic [tqsd_pkg::CNT_BITS-1:0] FULL_CNT =
        tqsd_pkg::CNT_BITS'(tqsd_pkg::QUEUE_DEPTH);
    localparam logic [tqsd_pkg::CNT_BITS:0] WRAP_SUM =
        (tqsd_pkg::CNT_BITS + 1)'(tqsd_pkg::QUEUE_DEPTH);
    localparam logic [tqsd_pkg::HEAD_BITS-1:0] LAST_SLOT =
        tqsd_pkg::HEAD_BITS'(tqsd_pkg::QUEUE_DEPTH - 1);

    always_comb begin
        any_wait   = (r_ecnt != '0) || (r_xcnt != '0);
        is_early   = (r_cur < i_cmd.arrival_time);
        take_exit  = (r_xcnt != '0) && ((r_ecnt == '0) || (r_last_use != tqsd_pkg::USE_ENTER));
        head_data  = take_exit ? r_exit_q[r_xhead] : r_enter_q[r_ehead];
        ecnt_after = take_exit ? r_ecnt : r_ecnt - tqsd_pkg::CNT_BITS'(1);
        xcnt_after = take_exit ? r_xcnt - tqsd_pkg::CNT_BITS'(1) : r_xcnt;
        after_wait = (ecnt_after != '0) || (xcnt_after != '0);
        ovf_after  = ((i_cmd.direction == tqsd_pkg::DIR_EXIT) ? xcnt_after : ecnt_after)
                     == FULL_CNT;
        ovf_now    = ((i_cmd.direction == tqsd_pkg::DIR_EXIT) ? r_xcnt : r_ecnt) == FULL_CNT;
        cur_inc    = r_cur + tqsd_pkg::TIME_BITS'(1);

        go        = i_cmd_valid && !i_res_full;
        do_grant  = go && any_wait && ((i_cmd.action == tqsd_pkg::ACT_FLUSH) || is_early);
        do_finish = go && (i_cmd.action == tqsd_pkg::ACT_ARRIVE) && !(any_wait && is_early);
        do_drop   = go && (i_cmd.action == tqsd_pkg::ACT_FLUSH) && !any_wait;

        if (i_cmd.action == tqsd_pkg::ACT_FLUSH) begin
            grant_last = !after_wait;
        end else begin
            grant_last = (!after_wait || (cur_inc == i_cmd.arrival_time)) && !ovf_after;
        end

        ecnt_sum  = {1'b0, tqsd_pkg::CNT_BITS'(r_ehead)} + {1'b0, r_ecnt};
        xcnt_sum  = {1'b0, tqsd_pkg::CNT_BITS'(r_xhead)} + {1'b0, r_xcnt};
        etail     = (ecnt_sum >= WRAP_SUM) ? tqsd_pkg::HEAD_BITS'(ecnt_sum - WRAP_SUM)
                                           : tqsd_pkg::HEAD_BITS'(ecnt_sum);
        xtail     = (xcnt_sum >= WRAP_SUM) ? tqsd_pkg::HEAD_BITS'(xcnt_sum - WRAP_SUM)
                                           : tqsd_pkg::HEAD_BITS'(xcnt_sum);
        ehead_inc = (r_ehead == LAST_SLOT) ? '0 : r_ehead + tqsd_pkg::HEAD_BITS'(1);
        xhead_inc = (r_xhead == LAST_SLOT) ? '0 : r_xhead + tqsd_pkg::HEAD_BITS'(1);

        o_cmd_pop = do_finish || do_drop ||
                    (do_grant && (i_cmd.action == tqsd_pkg::ACT_FLUSH) && !after_wait);
        o_res_wr  = do_grant || (do_finish && ovf_now);

        if (do_grant) begin
            o_res.granted_index     = head_data;
            o_res.cross_time        = r_cur;
            o_res.granted_direction = take_exit;
            o_res.overflow          = 1'b0;
            o_res.last              = grant_last;
        end else begin
            o_res.granted_index     = i_cmd.person_index;
            o_res.cross_time        = '0;
            o_res.granted_direction = i_cmd.direction;
            o_res.overflow          = 1'b1;
            o_res.last              = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_finish && !ovf_now) begin
            if (i_cmd.direction == tqsd_pkg::DIR_EXIT) begin
                r_exit_q[xtail] <= i_cmd.person_index;
            end else begin
                r_enter_q[etail] <= i_cmd.person_index;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ehead    <= '0;
            r_xhead    <= '0;
            r_ecnt     <= '0;
            r_xcnt     <= '0;
            r_cur      <= '0;
            r_last_use <= tqsd_pkg::USE_IDLE;
        end else if (do_grant) begin
            r_cur <= cur_inc;
            if (take_exit) begin
                r_xhead    <= xhead_inc;
                r_xcnt     <= xcnt_after;
                r_last_use <= tqsd_pkg::USE_EXIT;
            end else begin
                r_ehead    <= ehead_inc;
                r_ecnt     <= ecnt_after;
                r_last_use <= tqsd_pkg::USE_ENTER;
            end
        end else if (do_finish) begin
            if (is_early) begin
                r_cur      <= i_cmd.arrival_time;
                r_last_use <= tqsd_pkg::USE_IDLE;
            end
            if (!ovf_now) begin
                if (i_cmd.direction == tqsd_pkg::DIR_EXIT) begin
                    r_xcnt <= r_xcnt + tqsd_pkg::CNT_BITS'(1);
                end else begin
                    r_ecnt <= r_ecnt + tqsd_pkg::CNT_BITS'(1);
                end
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ecnt <= FULL_CNT) && (r_xcnt <= FULL_CNT))
        else $error("queue fill beyond depth");

    a_grant_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_wr && !o_res.overflow) |=> (r_cur == $past(cur_inc)))
        else $error("grant did not advance the second");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_wr && o_res.overflow) |->
        (((o_res.granted_direction == tqsd_pkg::DIR_EXIT) ? r_xcnt : r_ecnt) == FULL_CNT))
        else $error("overflow reported on a queue with room");

    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_grant && (r_ecnt != '0) && (r_xcnt != '0) && (r_last_use == tqsd_pkg::USE_ENTER))
        |-> !take_exit)
        else $error("enter lost a tie after an enter second");

    a_pop_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop || o_res_wr) |-> (i_cmd_valid && !i_res_full))
        else $error("engine acted without a request or result room");

endmodule

// ===== design/two_queue_sticky_direction_arbiter_unit.sv =====
`timescale 1ns / 1ps

// Door arbiter for two FIFO classes, enter and exit, one grant per second.
// Requests go into a two-entry request queue; a grant engine serves one
// second per clock cycle and writes results into a two-entry result queue.
// An arrival first grants waiting requests while the current second is
// before its arrival time, then queues it (or reports overflow); a flush
// grants every waiting request, or is dropped when both queues are empty. The
// engine stalls whenever the result queue is full. No clearing pass after
// reset: the block takes requests as soon as reset is released.

module two_queue_sticky_direction_arbiter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_action,
    input  logic [31:0] i_arrival_time,
    input  logic        i_direction,
    input  logic [15:0] i_person_index,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_granted_index,
    output logic [31:0] o_cross_time,
    output logic        o_granted_direction,
    output logic        o_overflow,
    output logic        o_last
);

    tqsd_pkg::t_cmd in_cmd;
    tqsd_pkg::t_cmd cmd;
    tqsd_pkg::t_res res;
    tqsd_pkg::t_res out_res;
    logic           cmd_empty;
    logic           cmd_pop;
    logic           res_full;
    logic           res_wr;

    assign in_cmd.action       = i_action;
    assign in_cmd.arrival_time = i_arrival_time;
    assign in_cmd.direction    = i_direction;
    assign in_cmd.person_index = i_person_index;

    tqsd_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (in_cmd),
        .o_full  (full),
        .i_rd    (cmd_pop),
        .o_rdata (cmd),
        .o_empty (cmd_empty)
    );

    tqsd_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_wr    (res_wr),
        .o_res       (res)
    );

    tqsd_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_wdata (res),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_rdata (out_res),
        .o_empty (empty)
    );

    assign o_granted_index     = out_res.granted_index;
    assign o_cross_time        = out_res.cross_time;
    assign o_granted_direction = out_res.granted_direction;
    assign o_overflow          = out_res.overflow;
    assign o_last              = out_res.last;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_PERIOD   = 12;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int REQUEST_GOAL = 310;
    localparam int MAX_REPORTS  = 100;

    class crossing_scoreboard;
        logic [tqsd_pkg::INDEX_BITS-1:0] enter_line[$];
        logic [tqsd_pkg::INDEX_BITS-1:0] exit_line[$];
        logic [tqsd_pkg::TIME_BITS-1:0]  now_second;
        logic [1:0]                      prev_use;
        tqsd_pkg::t_res                  due_grants[$];
        int                              errors;

        function new();
            now_second = '0;
            prev_use   = tqsd_pkg::USE_IDLE;
            errors     = 0;
        endfunction

        task report(string what);
            if (errors < MAX_REPORTS)
                $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        function int outstanding();
            return due_grants.size();
        endfunction

        function bit anyone_waiting();
            return enter_line.size() > 0 || exit_line.size() > 0;
        endfunction

        // grant the door for one second; exit wins unless enter had the last one
        function tqsd_pkg::t_res serve_second();
            tqsd_pkg::t_res r;
            logic take_exit;
            r = '0;
            take_exit = exit_line.size() > 0 &&
                        (enter_line.size() == 0 || prev_use != tqsd_pkg::USE_ENTER);
            if (take_exit) begin
                r.granted_index     = exit_line.pop_front();
                r.granted_direction = tqsd_pkg::DIR_EXIT;
                prev_use            = tqsd_pkg::USE_EXIT;
            end else begin
                r.granted_index     = enter_line.pop_front();
                r.granted_direction = tqsd_pkg::DIR_ENTER;
                prev_use            = tqsd_pkg::USE_ENTER;
            end
            r.cross_time = now_second;
            now_second   = now_second + tqsd_pkg::TIME_BITS'(1);
            return r;
        endfunction

        function void note_request(tqsd_pkg::t_cmd c);
            tqsd_pkg::t_res burst[$];
            tqsd_pkg::t_res r;
            if (c.action == tqsd_pkg::ACT_FLUSH) begin
                while (anyone_waiting())
                    burst.push_back(serve_second());
            end else begin
                while (now_second < c.arrival_time && anyone_waiting())
                    burst.push_back(serve_second());
                if (now_second < c.arrival_time) begin
                    prev_use   = tqsd_pkg::USE_IDLE;
                    now_second = c.arrival_time;
                end
                if ((c.direction == tqsd_pkg::DIR_EXIT ? exit_line.size() : enter_line.size())
                        >= tqsd_pkg::QUEUE_DEPTH) begin
                    r                   = '0;
                    r.granted_index     = c.person_index;
                    r.granted_direction = c.direction;
                    r.overflow          = 1'b1;
                    burst.push_back(r);
                end else if (c.direction == tqsd_pkg::DIR_EXIT) begin
                    exit_line.push_back(c.person_index);
                end else begin
                    enter_line.push_back(c.person_index);
                end
            end
            if (burst.size() > 0) begin
                r      = burst.pop_back();
                r.last = 1'b1;
                burst.push_back(r);
            end
            foreach (burst[i])
                due_grants.push_back(burst[i]);
        endfunction

        task check_result(tqsd_pkg::t_res got);
            tqsd_pkg::t_res want;
            if (due_grants.size() == 0) begin
                report($sformatf("unexpected result index %h time %h",
                                 got.granted_index, got.cross_time));
                return;
            end
            want = due_grants.pop_front();
            if (got.granted_index !== want.granted_index)
                report($sformatf("granted_index got %h expected %h",
                                 got.granted_index, want.granted_index));
            if (got.cross_time !== want.cross_time)
                report($sformatf("cross_time got %h expected %h",
                                 got.cross_time, want.cross_time));
            if (got.granted_direction !== want.granted_direction)
                report($sformatf("granted_direction got %b expected %b",
                                 got.granted_direction, want.granted_direction));
            if (got.overflow !== want.overflow)
                report($sformatf("overflow got %b expected %b",
                                 got.overflow, want.overflow));
            if (got.last !== want.last)
                report($sformatf("last got %b expected %b", got.last, want.last));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_action;
    logic [31:0] i_arrival_time;
    logic        i_direction;
    logic [15:0] i_person_index;
    logic        empty;
    logic        pop;
    logic [15:0] o_granted_index;
    logic [31:0] o_cross_time;
    logic        o_granted_direction;
    logic        o_overflow;
    logic        o_last;

    crossing_scoreboard sb;
    int requests_sent;
    int grants_taken;
    int idle_cycles;
    bit held_off;

    two_queue_sticky_direction_arbiter_unit i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_action            (i_action),
        .i_arrival_time      (i_arrival_time),
        .i_direction         (i_direction),
        .i_person_index      (i_person_index),
        .empty               (empty),
        .pop                 (pop),
        .o_granted_index     (o_granted_index),
        .o_cross_time        (o_cross_time),
        .o_granted_direction (o_granted_direction),
        .o_overflow          (o_overflow),
        .o_last              (o_last)
    );

    initial i_clk = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic offer_request(input logic act, input logic [31:0] at,
                                 input logic dir, input logic [15:0] who);
        tqsd_pkg::t_cmd c;
        int             gap;
        c.action       = act;
        c.arrival_time = at;
        c.direction    = dir;
        c.person_index = who;
        gap = (((requests_sent / 40) % 3) == 1) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push           <= 1'b1;
        i_action       <= c.action;
        i_arrival_time <= c.arrival_time;
        i_direction    <= c.direction;
        i_person_index <= c.person_index;
        do begin
            @(posedge i_clk);
        end while (full);
        sb.note_request(c);
        requests_sent++;
    endtask

    task automatic drain_results();
        tqsd_pkg::t_res got;
        int             gap;
        forever begin
            // hold off long enough to back up both internal queues
            if (grants_taken == 40 && !held_off) begin
                held_off = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = (((grants_taken / 50) % 3) == 2) ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (empty);
            got.granted_index     = o_granted_index;
            got.cross_time        = o_cross_time;
            got.granted_direction = o_granted_direction;
            got.overflow          = o_overflow;
            got.last              = o_last;
            sb.check_result(got);
            grants_taken++;
        end
    endtask

    task automatic run_directed();
        offer_request(tqsd_pkg::ACT_ARRIVE, 32'd0, tqsd_pkg::DIR_ENTER, 16'h0000);
        offer_request(tqsd_pkg::ACT_ARRIVE, 32'd0, tqsd_pkg::DIR_EXIT, 16'hFFFF);
        // release both, then skip the idle seconds up to the arrival
        offer_request(tqsd_pkg::ACT_ARRIVE, 32'd5, tqsd_pkg::DIR_ENTER, 16'h5A5A);
        offer_request(tqsd_pkg::ACT_ARRIVE, 32'd3, tqsd_pkg::DIR_EXIT, 16'hA5A5);
        offer_request(tqsd_pkg::ACT_FLUSH, 32'd0, tqsd_pkg::DIR_ENTER, 16'h0000);
        offer_request(tqsd_pkg::ACT_FLUSH, 32'hFFFF_FFFF, tqsd_pkg::DIR_EXIT, 16'hFFFF);
        for (int i = 0; i <= tqsd_pkg::QUEUE_DEPTH; i++)
            offer_request(tqsd_pkg::ACT_ARRIVE, 32'h8000_0000, tqsd_pkg::DIR_EXIT,
                          16'h0100 + i[15:0]);
        offer_request(tqsd_pkg::ACT_FLUSH, 32'h8000_0000, tqsd_pkg::DIR_ENTER, 16'h1234);
        // wrap the second counter
        offer_request(tqsd_pkg::ACT_ARRIVE, 32'hFFFF_FFFE, tqsd_pkg::DIR_EXIT, 16'h00F0);
        offer_request(tqsd_pkg::ACT_ARRIVE, 32'hFFFF_FFFE, tqsd_pkg::DIR_ENTER, 16'h00F1);
        offer_request(tqsd_pkg::ACT_ARRIVE, 32'hFFFF_FFFE, tqsd_pkg::DIR_EXIT, 16'h00F2);
        offer_request(tqsd_pkg::ACT_FLUSH, 32'hFFFF_FFFF, tqsd_pkg::DIR_EXIT, 16'h00F3);
    endtask

    task automatic run_random();
        logic [31:0] cursor;
        int          burst_left;
        logic        burst_dir;
        int          pick;
        cursor     = '0;
        burst_left = 0;
        burst_dir  = tqsd_pkg::DIR_ENTER;
        while (requests_sent < REQUEST_GOAL) begin
            if (burst_left > 0) begin
                burst_left--;
                offer_request(tqsd_pkg::ACT_ARRIVE, cursor, burst_dir,
                              16'($urandom_range(0, 65535)));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    offer_request(tqsd_pkg::ACT_FLUSH, $urandom, 1'($urandom_range(0, 1)),
                                  16'($urandom_range(0, 65535)));
                end else if (pick < 10) begin
                    burst_left = $urandom_range(8, 20);
                    burst_dir  = 1'($urandom_range(0, 1));
                end else begin
                    if (pick < 13)
                        cursor = cursor + $urandom;
                    else if (pick < 15)
                        cursor = $urandom;
                    else
                        cursor = cursor + $urandom_range(0, 3);
                    offer_request(tqsd_pkg::ACT_ARRIVE, cursor, 1'($urandom_range(0, 1)),
                                  16'($urandom_range(0, 65535)));
                end
            end
        end
    endtask

    initial begin
        sb             = new();
        requests_sent  = 0;
        grants_taken   = 0;
        idle_cycles    = 0;
        held_off       = 1'b0;
        i_rst_n        <= 1'b0;
        push           <= 1'b0;
        pop            <= 1'b0;
        i_action       <= tqsd_pkg::ACT_ARRIVE;
        i_arrival_time <= '0;
        i_direction    <= tqsd_pkg::DIR_ENTER;
        i_person_index <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            drain_results();
        join_none
        run_directed();
        run_random();
        push <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (2 * tqsd_pkg::QUEUE_DEPTH + 20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
